>>> hdl/rspd_pkg.sv
// ----------------------------------------------------------------------------
// rspd_pkg
// types, character codes and helpers for the packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package rspd_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_INTR   = 8'h03;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  localparam logic REG_NO_ACK      = 1'b0;
  localparam logic REG_MAX_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CK_HIGH = 2'd2,
    PH_CK_LOW  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_BYTE = 3'd0,
    KIND_GOOD = 3'd1,
    KIND_BAD  = 3'd2,
    KIND_LONG = 3'd3,
    KIND_INTR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REPLY_NONE  = 2'd0,
    REPLY_PLUS  = 2'd1,
    REPLY_MINUS = 2'd2,
    REPLY_E00   = 2'd3
  } reply_t;

  // value 0..15 for a hex digit, 16 otherwise
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/rsp_packet_deframer_top.sv
// One received link byte per item. Each accepted byte is latched in an input
// register and then parsed; a result, if the byte causes one, lands in the
// output register, which drives out_valid. The block accepts one item every
// cycle; the single parse stage with its packet state update sets that
// rate, and only a stalled output register with a pending result holds the
// input back.
// ----------------------------------------------------------------------------
// rsp_packet_deframer_top
// receive-side packet deframer for a debugger remote serial protocol link
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_packet_deframer_top
  import rspd_pkg::*;
#(
  parameter int BUFFER_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data,
  output logic [11:0]      out_length,
  output logic [1:0]       out_reply,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int          LIMIT_INT  = (BUFFER_BYTES - 1 > 4095) ? 4095 : BUFFER_BYTES - 1;
  localparam logic [11:0] HARD_LIMIT = 12'(LIMIT_INT);

  // configuration
  logic        no_ack_r;
  logic [11:0] max_payload_r;
  logic        cfg_wr;

  // input register
  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic        adv;
  logic        out_free;

  // packet state
  phase_t      phase_r, phase_nxt;
  logic [11:0] count_r, count_nxt;
  logic        ovf_r, ovf_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  check_high_r, check_high_nxt;

  // result register
  logic        out_vld_r, out_vld_nxt;
  kind_t       out_kind_r, res_kind;
  logic [7:0]  out_data_r, res_data;
  logic [11:0] out_length_r, res_length;
  reply_t      out_reply_r, res_reply;
  logic        res_vld;

  logic        skip;
  logic        intr;
  logic        fits;
  logic        sum_ok;
  logic [4:0]  hi_dig;
  logic [4:0]  lo_dig;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_ack_r      <= 1'b0;
      max_payload_r <= HARD_LIMIT;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_NO_ACK:      no_ack_r      <= cfg_pwdata[0];
        REG_MAX_PAYLOAD: max_payload_r <= cfg_pwdata[11:0];
        default:         no_ack_r      <= no_ack_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_NO_ACK:      cfg_prdata = {31'd0, no_ack_r};
      REG_MAX_PAYLOAD: cfg_prdata = {20'd0, max_payload_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // handshake
  assign out_free = !out_vld_r || !out_stall;
  assign adv      = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // byte classification
  assign skip   = (phase_r == PH_IDLE) &&
                  (s1_byte_r == CH_PLUS || s1_byte_r == CH_MINUS);
  assign intr   = !skip && (s1_byte_r == CH_INTR);
  assign fits   = (count_r < max_payload_r) && (count_r < HARD_LIMIT);
  assign hi_dig = hex_digit(check_high_r);
  assign lo_dig = hex_digit(s1_byte_r);
  assign sum_ok = !hi_dig[4] && !lo_dig[4] && ({hi_dig[3:0], lo_dig[3:0]} == sum_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (skip) begin
      phase_nxt = phase_r;
    end else if (intr) begin
      phase_nxt = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_IDLE:    if (s1_byte_r == CH_DOLLAR) phase_nxt = PH_PAYLOAD;
        PH_PAYLOAD: if (s1_byte_r == CH_HASH) phase_nxt = PH_CK_HIGH;
        PH_CK_HIGH: phase_nxt = PH_CK_LOW;
        PH_CK_LOW:  phase_nxt = PH_IDLE;
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  // packet counters and sum
  always_comb begin
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    sum_nxt        = sum_r;
    check_high_nxt = check_high_r;
    if (!skip) begin
      if (intr || phase_r == PH_CK_LOW ||
          (phase_r == PH_IDLE && s1_byte_r == CH_DOLLAR)) begin
        count_nxt      = 12'd0;
        ovf_nxt        = 1'b0;
        sum_nxt        = 8'd0;
        check_high_nxt = 8'd0;
      end else if (phase_r == PH_PAYLOAD) begin
        if (s1_byte_r != CH_HASH && !ovf_r) begin
          if (fits) begin
            count_nxt = count_r + 12'd1;
            sum_nxt   = sum_r + s1_byte_r;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end else if (phase_r == PH_CK_HIGH) begin
        check_high_nxt = s1_byte_r;
      end
    end
  end

  // result
  always_comb begin
    res_vld    = 1'b0;
    res_kind   = KIND_BYTE;
    res_data   = 8'd0;
    res_length = 12'd0;
    res_reply  = REPLY_NONE;
    if (!skip) begin
      if (intr) begin
        res_vld  = 1'b1;
        res_kind = KIND_INTR;
      end else begin
        unique case (phase_r)
          PH_PAYLOAD: begin
            if (s1_byte_r != CH_HASH && !ovf_r && fits) begin
              res_vld  = 1'b1;
              res_kind = KIND_BYTE;
              res_data = s1_byte_r;
            end
          end
          PH_CK_LOW: begin
            res_vld    = 1'b1;
            res_length = count_r;
            if (ovf_r) begin
              res_kind  = KIND_LONG;
              res_reply = REPLY_E00;
            end else if (sum_ok) begin
              res_kind  = KIND_GOOD;
              res_reply = no_ack_r ? REPLY_NONE : REPLY_PLUS;
            end else begin
              res_kind  = KIND_BAD;
              res_reply = no_ack_r ? REPLY_NONE : REPLY_MINUS;
            end
          end
          default: res_vld = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      count_r      <= 12'd0;
      ovf_r        <= 1'b0;
      sum_r        <= 8'd0;
      check_high_r <= 8'd0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      sum_r        <= sum_nxt;
      check_high_r <= check_high_nxt;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (adv) begin
      out_vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_length_r <= res_length;
      out_reply_r  <= res_reply;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_kind   = out_kind_r;
  assign out_data   = out_data_r;
  assign out_length = out_length_r;
  assign out_reply  = out_reply_r;

`ifndef NO_ASSERTIONS
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (count_r == 12'd0 && !ovf_r && sum_r == 8'd0))
    else $error("packet state not cleared while idle");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= HARD_LIMIT)
    else $error("payload count beyond buffer limit");

  a_ovf_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (phase_r != PH_IDLE))
    else $error("overflow flag set while idle");

  a_long_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r == KIND_LONG) |-> (out_reply_r == REPLY_E00))
    else $error("overflow verdict without error reply");

  a_no_stall_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && in_stall) |=> s1_vld_r)
    else $error("held item lost from input register");
`endif

endmodule

`default_nettype wire
